FILE: design/kmee_pkg.sv
// ----------------------------------------------------------------------------
// Keyboard matrix event encoder package
// Shared widths, scan-code table, key codes, queue entry and state types.
// ----------------------------------------------------------------------------
package kmee_pkg;

    localparam int ROW_COUNT    = 8;
    localparam int COLUMN_COUNT = 9;
    localparam int TABLE_ROWS   = 8;
    localparam int TABLE_COLS   = 9;

    localparam int ROW_W     = 3;
    localparam int COL_W     = 9;
    localparam int CODE_W    = 8;
    localparam int COL_IDX_W = (COL_W > 1) ? $clog2(COL_W) : 1;
    localparam int ROW_IDX_W = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [ROW_W-1:0]     row_t;
    typedef logic [COL_W-1:0]     cols_t;
    typedef logic [CODE_W-1:0]    code_t;
    typedef logic [COL_IDX_W-1:0] col_idx_t;

    localparam code_t RELEASE_FLAG = 8'h80;
    localparam code_t CODE_LSHIFT  = 8'h2a;
    localparam code_t CODE_RSHIFT  = 8'h36;
    localparam code_t CODE_CAPS    = 8'h3a;
    localparam code_t CODE_CTRL    = 8'h1d;
    localparam code_t CODE_ALT     = 8'h5c;
    localparam code_t CODE_OS      = 8'h5b;
    localparam code_t CODE_STOP    = 8'h61;
    localparam code_t CODE_C       = 8'h2e;

    localparam code_t MOD_CAPS  = 8'h04;
    localparam code_t MOD_SHIFT = 8'h08;
    localparam code_t MOD_CTRL  = 8'h10;
    localparam code_t MOD_ALT   = 8'h20;
    localparam code_t MOD_OS    = 8'h40;

    localparam int CAPS_BIT = 2;

    // One queued row: its row number, the new column state and the
    // columns that still have to produce an event.
    typedef struct packed {
        row_t  row;
        cols_t now;
        cols_t emit;
    } job_t;

    typedef enum logic {
        BACK_IDLE,
        BACK_EMIT
    } back_state_t;

    localparam code_t CODE_TABLE [TABLE_ROWS][TABLE_COLS] = '{
        '{8'h65, 8'h1c, 8'h69, 8'h41, 8'h3b, 8'h3d, 8'h3f, 8'h68, 8'h6a},
        '{8'h04, 8'h11, 8'h1e, 8'h05, 8'h2c, 8'h1f, 8'h12, 8'h2a, 8'h00},
        '{8'h06, 8'h13, 8'h20, 8'h07, 8'h2e, 8'h21, 8'h14, 8'h2d, 8'h00},
        '{8'h08, 8'h15, 8'h22, 8'h09, 8'h30, 8'h23, 8'h16, 8'h2f, 8'h00},
        '{8'h0a, 8'h17, 8'h24, 8'h0b, 8'h32, 8'h25, 8'h18, 8'h31, 8'h00},
        '{8'h0c, 8'h19, 8'h26, 8'h3a, 8'h34, 8'h27, 8'h1a, 8'h33, 8'h00},
        '{8'h0d, 8'h1b, 8'h28, 8'h63, 8'h36, 8'h5c, 8'h0f, 8'h35, 8'h6b},
        '{8'h02, 8'h01, 8'h1d, 8'h03, 8'h39, 8'h5b, 8'h10, 8'h61, 8'h00}
    };

    function automatic code_t code_lookup(input row_t row, input col_idx_t col);
        code_t result;
        result = '0;
        if ((int'(row) < TABLE_ROWS) && (int'(col) < TABLE_COLS))
        begin
            result = CODE_TABLE[row][col];
        end
        return result;
    endfunction

    function automatic cols_t column_mask();
        cols_t m;
        for (int i = 0; i < COL_W; i++)
        begin
            m[i] = (i < COLUMN_COUNT);
        end
        return m;
    endfunction

    // Columns of a row that carry a nonzero scan code
    function automatic cols_t coded_columns(input row_t row);
        cols_t m;
        for (int i = 0; i < COL_W; i++)
        begin
            m[i] = (code_lookup(row, col_idx_t'(i)) != '0);
        end
        return m;
    endfunction

endpackage

FILE: design/kmee_front.sv
// ----------------------------------------------------------------------------
// Front end
// Accepts scanned rows, diffs them against the row store and queues the
// columns that must produce events.
// ----------------------------------------------------------------------------
module kmee_front
    import kmee_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  row_t  row_number,
    input  cols_t column_bits,
    input  logic  queue_full,
    output logic  job_push,
    output job_t  job_data
);

    cols_t store_reg [ROW_COUNT];

    logic                 accept;
    logic                 row_ok;
    logic [ROW_IDX_W-1:0] row_idx;
    cols_t                now_bits;
    cols_t                changed;
    cols_t                emit;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;
    assign row_ok   = (int'(row_number) < ROW_COUNT);
    assign row_idx  = row_number[ROW_IDX_W-1:0];
    assign now_bits = column_bits & column_mask();
    assign changed  = store_reg[row_idx] ^ now_bits;
    assign emit     = changed & coded_columns(row_number);

    assign job_push      = accept && row_ok && (emit != '0);
    assign job_data.row  = row_number;
    assign job_data.now  = now_bits;
    assign job_data.emit = emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ROW_COUNT; i++)
            begin
                store_reg[i] <= '0;
            end
        end
        else if (accept && row_ok)
        begin
            store_reg[row_idx] <= now_bits;
        end
    end

endmodule

FILE: design/kmee_queue.sv
// ----------------------------------------------------------------------------
// Row queue
// Small FIFO of pending rows between the front and back ends.
// ----------------------------------------------------------------------------
module kmee_queue
    import kmee_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_data,
    output logic full,
    input  logic pop,
    output job_t pop_data,
    output logic empty
);

    job_t                entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;
    logic                do_push;
    logic                do_pop;

    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                                                                     : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                                                                     : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: design/kmee_back.sv
// ----------------------------------------------------------------------------
// Back end
// Walks the queued columns lowest first, tracks the modifier byte and
// registers one event per cycle, unless the output stalls, into the output stage.
// ----------------------------------------------------------------------------
module kmee_back
    import kmee_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  queue_empty,
    input  job_t  queue_data,
    output logic  queue_pop,
    output logic  out_valid,
    input  logic  out_ready,
    output code_t key_code,
    output code_t modifier_bits,
    output logic  caps_led,
    output logic  break_request,
    output logic  last_of_row
);

    back_state_t state_reg;
    back_state_t state_next;
    job_t        job_reg;
    cols_t       rem_reg;
    cols_t       rem_next;
    code_t       mod_reg;
    code_t       mod_next;

    logic        out_valid_reg;
    code_t       key_code_reg;
    code_t       mod_out_reg;
    logic        break_reg;
    logic        last_reg;

    logic        load;
    logic        fire;
    col_idx_t    col;
    code_t       table_code;
    logic        pressed;
    code_t       event_code;
    logic        event_break;

    function automatic col_idx_t lowest_col(input cols_t m);
        col_idx_t idx;
        idx = '0;
        for (int i = COL_W - 1; i >= 0; i--)
        begin
            if (m[i])
            begin
                idx = col_idx_t'(i);
            end
        end
        return idx;
    endfunction

    function automatic code_t apply_mod(input code_t m, input code_t code, input logic down);
        code_t r;
        code_t bit_sel;
        r       = m;
        bit_sel = '0;
        case (code)
            CODE_LSHIFT, CODE_RSHIFT: bit_sel = MOD_SHIFT;
            CODE_CTRL:                bit_sel = MOD_CTRL;
            CODE_ALT:                 bit_sel = MOD_ALT;
            CODE_OS:                  bit_sel = MOD_OS;
            default:                  bit_sel = '0;
        endcase
        if (code == CODE_CAPS)
        begin
            if (down)
            begin
                r = m ^ MOD_CAPS;
            end
        end
        else if (down)
        begin
            r = m | bit_sel;
        end
        else
        begin
            r = m & ~bit_sel;
        end
        return r;
    endfunction

    assign col         = lowest_col(rem_reg);
    assign table_code  = code_lookup(job_reg.row, col);
    assign pressed     = job_reg.now[col];
    assign mod_next    = apply_mod(mod_reg, table_code, pressed);
    assign event_code  = pressed ? table_code : (table_code | RELEASE_FLAG);
    assign event_break = (event_code == CODE_STOP) ||
                         ((event_code == CODE_C) && ((mod_next & MOD_CTRL) != '0));
    assign rem_next    = rem_reg & ~(cols_t'(1) << col);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BACK_IDLE:
            begin
                if (!queue_empty)
                begin
                    state_next = BACK_EMIT;
                end
            end
            BACK_EMIT:
            begin
                if (fire && (rem_next == '0))
                begin
                    state_next = BACK_IDLE;
                end
            end
            default:
            begin
                state_next = BACK_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        load = 1'b0;
        fire = 1'b0;
        case (state_reg)
            BACK_IDLE:
            begin
                load = !queue_empty;
            end
            BACK_EMIT:
            begin
                fire = !out_valid_reg || out_ready;
            end
            default:
            begin
                load = 1'b0;
                fire = 1'b0;
            end
        endcase
    end

    assign queue_pop = load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BACK_IDLE;
            mod_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (fire)
            begin
                mod_reg       <= mod_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            job_reg <= queue_data;
            rem_reg <= queue_data.emit;
        end
        else if (fire)
        begin
            rem_reg <= rem_next;
        end
        if (fire)
        begin
            key_code_reg <= event_code;
            mod_out_reg  <= mod_next;
            break_reg    <= event_break;
            last_reg     <= (rem_next == '0);
        end
    end

    assign out_valid     = out_valid_reg;
    assign key_code      = key_code_reg;
    assign modifier_bits = mod_out_reg;
    assign caps_led      = mod_out_reg[CAPS_BIT];
    assign break_request = break_reg;
    assign last_of_row   = last_reg;

endmodule

FILE: design/key_matrix_event_encoder.sv
// ----------------------------------------------------------------------------
// Keyboard matrix event encoder
// Row diff front end, two-row queue, serial event back end.
// ----------------------------------------------------------------------------
// The first event of a row passes the row queue, the back end's job register and
// its output stage. Events of a row (up to nine) leave one by one, held while the
// output stalls; the next row loads after the last. Rows without events skip the queue.
// The two-entry row queue lets the input side run ahead of the output side.
// Reset: row store, modifier byte, queue pointers and output valid clear asynchronously.
// ----------------------------------------------------------------------------
module key_matrix_event_encoder
    import kmee_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  row_t  row_number,
    input  cols_t column_bits,
    output logic  out_valid,
    input  logic  out_ready,
    output code_t key_code,
    output code_t modifier_bits,
    output logic  caps_led,
    output logic  break_request,
    output logic  last_of_row
);

    logic job_push;
    job_t job_in;
    logic queue_full;
    logic queue_pop;
    job_t job_out;
    logic queue_empty;

    kmee_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .row_number  (row_number),
        .column_bits (column_bits),
        .queue_full  (queue_full),
        .job_push    (job_push),
        .job_data    (job_in)
    );

    kmee_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_data (job_in),
        .full      (queue_full),
        .pop       (queue_pop),
        .pop_data  (job_out),
        .empty     (queue_empty)
    );

    kmee_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .queue_empty   (queue_empty),
        .queue_data    (job_out),
        .queue_pop     (queue_pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .key_code      (key_code),
        .modifier_bits (modifier_bits),
        .caps_led      (caps_led),
        .break_request (break_request),
        .last_of_row   (last_of_row)
    );

endmodule

FILE: design/kmee_checker.sv
// ----------------------------------------------------------------------------
// Event encoder checker
// Port-level properties of the encoder output, bound to the top level.
// ----------------------------------------------------------------------------
module kmee_checker
    import kmee_pkg::*;
(
    input logic  clk,
    input logic  rst_n,
    input logic  out_valid,
    input logic  out_ready,
    input code_t key_code,
    input code_t modifier_bits,
    input logic  caps_led,
    input logic  break_request,
    input logic  last_of_row
);

    a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("output valid during reset");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(key_code)
            && $stable(modifier_bits) && $stable(last_of_row))
        else $error("stalled transaction changed");

    a_caps_led: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> caps_led == modifier_bits[CAPS_BIT])
        else $error("caps LED disagrees with modifier byte");

    a_break_press: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && break_request |-> !key_code[7]
            && (key_code == CODE_STOP || (modifier_bits & MOD_CTRL) != '0))
        else $error("break request on a release or without ctrl");

endmodule

bind key_matrix_event_encoder kmee_checker u_kmee_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .key_code      (key_code),
    .modifier_bits (modifier_bits),
    .caps_led      (caps_led),
    .break_request (break_request),
    .last_of_row   (last_of_row)
);
